// ----- src/ifd_pkg.sv -----
// Shared types, codes and the field length table of the ISO 8583 field deframer.
`default_nettype none
package ifd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ifd_in_t;

  typedef struct packed {
    logic [7:0] field_number;
    logic [7:0] out_byte;
    logic       field_last;
    logic       message_end;
    logic       empty_field;
    logic [1:0] error_code;
  } ifd_out_t;

  // Byte classes from the front end
  localparam logic [1:0] KIND_MTI    = 2'd0;
  localparam logic [1:0] KIND_BITMAP = 2'd1;
  localparam logic [1:0] KIND_BODY   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       done;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] idx;
  } ifd_tok_t;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_UNSUP = 2'd2;
  localparam logic [1:0] ERR_DIGIT = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  localparam int MTI_BYTES = 4;

  // len holds the fixed byte count, or the number of prefix digits when is_var
  typedef struct packed {
    logic       supported;
    logic       is_var;
    logic [4:0] len;
  } ifd_fkind_t;

  function automatic ifd_fkind_t field_kind(input logic [7:0] n);
    ifd_fkind_t k;
    k = '0;
    case (n)
      8'd2:    k = '{supported: 1'b1, is_var: 1'b1, len: 5'd2};
      8'd3:    k = '{supported: 1'b1, is_var: 1'b0, len: 5'd6};
      8'd7:    k = '{supported: 1'b1, is_var: 1'b0, len: 5'd10};
      8'd11:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd6};
      8'd12:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd6};
      8'd13:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd4};
      8'd14:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd4};
      8'd22:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd3};
      8'd24:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd3};
      8'd25:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd2};
      8'd35:   k = '{supported: 1'b1, is_var: 1'b1, len: 5'd2};
      8'd41:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd8};
      8'd42:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd15};
      8'd48:   k = '{supported: 1'b1, is_var: 1'b1, len: 5'd3};
      8'd49:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd3};
      8'd52:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd16};
      8'd53:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd16};
      8'd64:   k = '{supported: 1'b1, is_var: 1'b0, len: 5'd16};
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ----- src/ifd_fifo.sv -----
// Small register queue with full and empty flags.
`default_nettype none
module ifd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] FULL_CNT = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/ifd_front.sv -----
// Front end: frames each message and classifies bytes as MTI, bitmap or body.
`default_nettype none
module ifd_front
  import ifd_pkg::*;
#(
  parameter int BITMAP_BITS = 128
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire logic     full,
  input  wire ifd_in_t  item,
  output logic          tok_push,
  output ifd_tok_t      tok
);
  localparam logic [1:0] FR_MTI    = 2'd0;
  localparam logic [1:0] FR_BITMAP = 2'd1;
  localparam logic [1:0] FR_BODY   = 2'd2;
  localparam logic       SEC_OK    = (BITMAP_BITS > 64);
  localparam logic [3:0] MTI_LAST  = 4'(MTI_BYTES - 1);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] cnt;
  logic [3:0] cnt_next;
  logic       sec;
  logic       sec_next;
  logic       accept;

  assign accept   = push && !full;
  assign tok_push = accept;

  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    sec_next      = sec;
    tok           = '0;
    tok.data_byte = item.data_byte;
    tok.last_byte = item.last_byte;
    tok.idx       = cnt;
    case (phase)
      FR_MTI: begin
        tok.kind = KIND_MTI;
        tok.done = (cnt == MTI_LAST);
        cnt_next = cnt + 4'd1;
        if (tok.done) begin
          phase_next = FR_BITMAP;
          cnt_next   = '0;
        end
      end
      FR_BITMAP: begin
        tok.kind = KIND_BITMAP;
        if (cnt == 4'd0) begin
          sec_next = item.data_byte[7];
        end
        tok.done = ((cnt == 4'd7) && !(SEC_OK && sec)) || (cnt == 4'd15);
        cnt_next = cnt + 4'd1;
        if (tok.done) begin
          phase_next = FR_BODY;
          cnt_next   = '0;
        end
      end
      default: begin
        tok.kind = KIND_BODY;
      end
    endcase
    // A message always ends on its flagged byte
    if (item.last_byte) begin
      phase_next = FR_MTI;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= FR_MTI;
      cnt   <= '0;
      sec   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      sec   <= sec_next;
    end
  end
endmodule
`default_nettype wire

// ----- src/ifd_back.sv -----
// Back end: holds the bitmap, walks set bits and cuts fields into tagged results.
`default_nettype none
module ifd_back
  import ifd_pkg::*;
#(
  parameter int BITMAP_BITS = 128
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ifd_tok_t tok,
  input  wire logic     tok_avail,
  output logic          tok_take,
  input  wire logic     res_room,
  output logic          res_push,
  output ifd_out_t      res
);
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_IDLE   = 2'd2;

  logic [1:0]             phase;
  logic [1:0]             phase_next;
  logic [7:0]             cur;
  logic [7:0]             cur_next;
  logic [9:0]             rem;
  logic [9:0]             rem_next;
  logic [1:0]             left;
  logic [1:0]             left_next;
  logic [BITMAP_BITS:1]   pending;
  logic [BITMAP_BITS:1]   pending_next;
  logic [BITMAP_BITS:1]   pend_cur;

  logic       found;
  logic [7:0] nxt;
  ifd_fkind_t fk;
  logic       res_valid;
  logic       do_after;
  logic       digit_ok;
  logic [9:0] rem_calc;
  logic [9:0] rem_dec;

  assign tok_take = tok_avail && res_room;
  assign res_push = tok_take && res_valid;

  // Merge the arriving bitmap byte; bit 1 only flags the secondary map
  always_comb begin
    pend_cur = pending;
    if (tok.kind == KIND_BITMAP) begin
      for (int f = 2; f <= BITMAP_BITS; f++) begin
        if (4'((f - 1) / 8) == tok.idx) begin
          pend_cur[f] = tok.data_byte[7 - ((f - 1) % 8)];
        end
      end
    end
  end

  // Lowest numbered field still pending
  always_comb begin
    found = 1'b0;
    nxt   = '0;
    for (int f = BITMAP_BITS; f >= 2; f--) begin
      if (pend_cur[f]) begin
        found = 1'b1;
        nxt   = 8'(f);
      end
    end
  end

  assign fk       = field_kind(nxt);
  assign digit_ok = tok.data_byte inside {[ASCII_ZERO:ASCII_NINE]};
  assign rem_calc = {rem[6:0], 3'b000} + {rem[8:0], 1'b0} + {6'd0, tok.data_byte[3:0]};
  assign rem_dec  = (rem != '0) ? (rem - 10'd1) : rem;

  always_comb begin
    phase_next   = phase;
    cur_next     = cur;
    rem_next     = rem;
    left_next    = left;
    pending_next = pending;
    res          = '0;
    res_valid    = 1'b0;
    do_after     = 1'b0;
    case (tok.kind)
      KIND_MTI: begin
        res_valid        = 1'b1;
        res.out_byte     = tok.data_byte;
        res.field_last   = tok.done;
        res.error_code   = tok.last_byte ? ERR_SHORT : ERR_OK;
        pending_next     = '0;
      end
      KIND_BITMAP: begin
        res_valid        = 1'b1;
        res.field_number = 8'd1;
        res.out_byte     = tok.data_byte;
        res.field_last   = tok.done;
        pending_next     = pend_cur;
        if (tok.done) begin
          do_after = 1'b1;
        end else if (tok.last_byte) begin
          res.error_code = ERR_SHORT;
        end
      end
      KIND_BODY: begin
        res.field_number = cur;
        case (phase)
          PH_PREFIX: begin
            if (!digit_ok) begin
              res_valid      = 1'b1;
              res.error_code = ERR_DIGIT;
              phase_next     = PH_IDLE;
            end else begin
              rem_next  = rem_calc;
              left_next = left - 2'd1;
              if (left_next != '0) begin
                if (tok.last_byte) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_SHORT;
                end
              end else if (rem_calc == '0) begin
                res_valid       = 1'b1;
                res.field_last  = 1'b1;
                res.empty_field = 1'b1;
                do_after        = 1'b1;
              end else begin
                phase_next = PH_DATA;
                if (tok.last_byte) begin
                  res_valid      = 1'b1;
                  res.error_code = ERR_SHORT;
                end
              end
            end
          end
          PH_DATA: begin
            res_valid    = 1'b1;
            res.out_byte = tok.data_byte;
            rem_next     = rem_dec;
            if (rem_dec == '0) begin
              res.field_last = 1'b1;
              do_after       = 1'b1;
            end else if (tok.last_byte) begin
              res.error_code = ERR_SHORT;
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase

    // Step to the next selected field once the current one completes
    if (do_after) begin
      if (!found) begin
        res.message_end = 1'b1;
        phase_next      = PH_IDLE;
      end else if (!fk.supported) begin
        res.error_code = ERR_UNSUP;
        cur_next       = nxt;
        phase_next     = PH_IDLE;
      end else begin
        cur_next = nxt;
        for (int f = 2; f <= BITMAP_BITS; f++) begin
          if (nxt == 8'(f)) begin
            pending_next[f] = 1'b0;
          end
        end
        if (fk.is_var) begin
          phase_next = PH_PREFIX;
          left_next  = fk.len[1:0];
          rem_next   = '0;
        end else begin
          phase_next = PH_DATA;
          rem_next   = {5'd0, fk.len};
        end
        if (tok.last_byte) begin
          res.error_code = ERR_SHORT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      cur     <= '0;
      rem     <= '0;
      left    <= '0;
      pending <= '0;
    end else if (tok_take) begin
      phase   <= phase_next;
      cur     <= cur_next;
      rem     <= rem_next;
      left    <= left_next;
      pending <= pending_next;
    end
  end
endmodule
`default_nettype wire

// ----- src/iso8583_field_deframer.sv -----
// ISO 8583 field deframer: splits a raw message byte stream into field-tagged bytes.
// Input channel: present a byte on item with push high; it is taken on any clock
// edge where full is low. item.last_byte marks the final byte of a message and the
// next byte taken starts a new message at the MTI.
// Result channel: while empty is low, result holds the oldest result; raise pop to
// take it. Each byte gives at most one result; a length prefix digit gives one only
// for an error or empty field; bytes after the final field or an error give none.
// Path: a taken byte is classified by the front and registered in a 4-entry
// middle queue; the back field walker then registers its result in a 4-entry
// result queue, from which it can be popped.
// Throughput: one byte per cycle sustained while full is low; the back stage handles
// one queued byte per cycle while the result queue has room, bounded by the priority
// encoder that finds the next set bitmap bit and the field length lookup behind it.
// Reset (rst, synchronous): both queues empty, parser waits for an MTI.
// When the receiver stops popping, the result queue fills, the back stage holds,
// the middle queue fills and full rises; nothing is dropped.
`default_nettype none
module iso8583_field_deframer
  import ifd_pkg::*;
#(
  parameter int BITMAP_BITS = 128
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire ifd_in_t  item,
  output logic          empty,
  input  wire logic     pop,
  output ifd_out_t      result
);
  localparam int QDEPTH = 4;

  ifd_tok_t front_tok;
  logic     front_push;
  ifd_tok_t mid_tok;
  logic     mid_empty;
  logic     mid_take;
  logic     out_full;
  logic     res_push;
  ifd_out_t res;
  logic [$bits(ifd_tok_t)-1:0] mid_rd;
  logic [$bits(ifd_out_t)-1:0] out_rd;

  ifd_front #(.BITMAP_BITS(BITMAP_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .tok_push (front_push),
    .tok      (front_tok)
  );

  ifd_fifo #(.WIDTH($bits(ifd_tok_t)), .DEPTH(QDEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_tok),
    .full    (full),
    .rd_en   (mid_take),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  assign mid_tok = ifd_tok_t'(mid_rd);

  ifd_back #(.BITMAP_BITS(BITMAP_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (mid_tok),
    .tok_avail (!mid_empty),
    .tok_take  (mid_take),
    .res_room  (!out_full),
    .res_push  (res_push),
    .res       (res)
  );

  ifd_fifo #(.WIDTH($bits(ifd_out_t)), .DEPTH(QDEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_rd),
    .empty   (empty)
  );

  assign result = ifd_out_t'(out_rd);

  a_no_result_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result written into a full result queue");

  a_accept_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !mid_empty)
    else $error("accepted byte missing from middle queue");

  a_end_closes_field: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.message_end || result.error_code == ERR_UNSUP))
      |-> result.field_last)
    else $error("message end or unsupported field without field completion");

  a_empty_field_no_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.empty_field) |-> (result.field_last && result.out_byte == 8'd0))
    else $error("empty field result carries a byte");
endmodule
`default_nettype wire
